[sv/tskd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tskd_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 34;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON0       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_COUNT = 3'd5;

   localparam logic [3:0] CONFIRM_COUNT_RESET = 4'd6;
   localparam logic [3:0] CONFIRM_COUNT_RF    = 4'd1;

   // Hit test and RF correction constants.
   localparam logic [9:0] EDGE_SHRINK  = 10'd2;
   localparam logic [8:0] RF_TOP_Y     = 9'd210;
   localparam logic [9:0] RF_Y_OFFSET  = 10'd40;
   localparam logic [7:0] RF_X_MAX     = 8'd240;
   localparam logic [7:0] RF_DIV_A     = 8'd10;
   localparam logic [7:0] RF_DIV_B     = 8'd70;
   // Reciprocal of ten in 11 fractional bits, exact for all 8-bit values.
   localparam logic [15:0] DIV10_MUL   = 16'd205;

   // Rectangle as packed in a button register.
   typedef struct packed {
      logic [8:0] bottom;
      logic [7:0] right;
      logic [8:0] top;
      logic [7:0] left;
   } button_rect_type;

   typedef enum logic [1:0] {
      PHASE_WAIT    = 2'd0,
      PHASE_CONFIRM = 2'd1,
      PHASE_PRESSED = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      TP_TRIGGER  = 2'd0,
      TP_PRESSING = 2'd1,
      TP_RELEASE  = 2'd2
   } touch_phase_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_PRESS   = 2'd1,
      EV_RELEASE = 2'd2,
      EV_CANCEL  = 2'd3
   } key_event_type;

   function automatic logic [4:0] div_by_ten(input logic [7:0] v);
      logic [15:0] prod;
      prod = 16'(v) * DIV10_MUL;
      return prod[15:11];
   endfunction

   // Quotient by seventy of a value no larger than 240.
   function automatic logic [1:0] div_by_seventy(input logic [7:0] v);
      logic [1:0] q;
      if (v >= 8'(3 * 70)) begin
         q = 2'd3;
      end else if (v >= 8'(2 * 70)) begin
         q = 2'd2;
      end else if (v >= RF_DIV_B) begin
         q = 2'd1;
      end else begin
         q = 2'd0;
      end
      return q;
   endfunction

endpackage

`default_nettype wire

[sv/tskd_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tskd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] touch_x;
   logic [8:0] touch_y;
   logic       touching;
   logic       rf_active;

   modport source(output valid, output touch_x, output touch_y, output touching,
                  output rf_active, input ready);
   modport sink(input valid, input touch_x, input touch_y, input touching,
                input rf_active, output ready);
endinterface

`default_nettype wire

[sv/tskd_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tskd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] key_event;
   logic [1:0] key_index;

   modport source(output valid, output key_event, output key_index, input ready);
   modport sink(input valid, input key_event, input key_index, output ready);
endinterface

`default_nettype wire

[sv/touch_soft_key_detector.sv]
// A word accepted on req_if passes through the input register and then the result
// register before it is presented on rsp_if; a stall on rsp_if holds it there.
// Throughput: one word per cycle while rsp_if keeps up; the hit test and the
// phase update of a sample fit in the single logic stage between the registers.
// Reset (synchronous, active high) returns the phase machine to waiting,
// clears both valid flags and restores every configuration register.
`timescale 1ns / 1ps
`default_nettype none

module touch_soft_key_detector #(
   parameter int NUM_BUTTONS = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tskd_req_if.sink                            req_if,
   tskd_rsp_if.source                          rsp_if,
   input  wire logic                           csr_wr_en,
   input  wire logic [tskd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tskd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tskd_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers. Only NUM_BUTTONS rectangles are kept;
   // writes to the others are dropped, as are writes beyond the list.
   // ------------------------------------------------------------------
   button_rect_type        rect_ff [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] enable_mask_ff;
   logic [3:0]             confirm_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            rect_ff[i] <= '0;
         end
         enable_mask_ff   <= '0;
         confirm_count_ff <= CONFIRM_COUNT_RESET;
      end else if (csr_wr_en) begin
         for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (csr_index == CSR_BUTTON0 + CSR_INDEX_W'(i)) begin
               rect_ff[i] <= csr_wdata;
            end
         end
         if (csr_index == CSR_ENABLE_MASK) begin
            enable_mask_ff <= csr_wdata[NUM_BUTTONS-1:0];
         end
         if (csr_index == CSR_CONFIRM_COUNT) begin
            confirm_count_ff <= csr_wdata[3:0];
         end
      end
   end

   // ------------------------------------------------------------------
   // Handshake. The input register advances whenever the result register
   // is empty or being drained, so words stream in every cycle while rsp_if
   // keeps up. While a finished result waits on rsp_if, an empty input
   // register can still take one word and then holds it.
   // ------------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] x_ff;
   logic [8:0] y_ff;
   logic       touching_ff;
   logic       rf_ff;
   logic       rsp_valid_ff;
   logic [1:0] rsp_event_ff;
   logic [1:0] rsp_index_ff;

   logic out_load;
   logic advance;
   logic req_take;

   assign out_load  = !rsp_valid_ff || rsp_if.ready;
   assign advance   = in_valid_ff && out_load;
   assign req_if.ready = !in_valid_ff || out_load;
   assign req_take  = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         x_ff        <= req_if.touch_x;
         y_ff        <= req_if.touch_y;
         touching_ff <= req_if.touching;
         rf_ff       <= req_if.rf_active;
      end
   end

   // ------------------------------------------------------------------
   // RF correction of y near the bottom edge. The quotients by ten and by
   // seventy are reciprocal multiplies and compares. For x beyond 240 the
   // offset term (240 - x) / 10 truncates to zero up to 249 and to minus
   // one from 250 on, and the threshold term is zero.
   // ------------------------------------------------------------------
   logic       x_in_range;
   logic [7:0] x_gap;
   logic [4:0] x_tenth;
   logic [4:0] gap_tenth;
   logic [1:0] gap_seventieth;
   logic [8:0] rf_threshold;
   logic [9:0] y_shift;
   logic [9:0] y_hit;

   always_comb begin
      x_in_range     = x_ff <= RF_X_MAX;
      x_gap          = x_in_range ? (RF_X_MAX - x_ff) : 8'd0;
      x_tenth        = div_by_ten(x_ff);
      gap_tenth      = div_by_ten(x_gap);
      gap_seventieth = div_by_seventy(x_gap);
      rf_threshold   = 9'(x_tenth) + RF_TOP_Y + 9'(gap_seventieth);

      if (x_in_range) begin
         y_shift = RF_Y_OFFSET + 10'(gap_tenth);
      end else if (x_ff >= RF_X_MAX + RF_DIV_A) begin
         y_shift = RF_Y_OFFSET - 10'd1;
      end else begin
         y_shift = RF_Y_OFFSET;
      end

      if (rf_ff && (y_ff > rf_threshold)) begin
         y_hit = 10'(y_ff) + y_shift;
      end else begin
         y_hit = 10'(y_ff);
      end
   end

   // ------------------------------------------------------------------
   // Hit test: every button is compared in parallel against its rectangle
   // shrunk by two on each side; the lowest enabled match wins. The shrink
   // is applied to the point side of the right and bottom edges so that
   // all terms stay unsigned and a collapsed rectangle simply never hits.
   // ------------------------------------------------------------------
   logic       hit_valid;
   logic [1:0] hit_index;

   always_comb begin
      logic [9:0] x_wide;
      x_wide    = 10'(x_ff);
      hit_valid = 1'b0;
      hit_index = 2'd0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (enable_mask_ff[i] &&
             (10'(rect_ff[i].left) + EDGE_SHRINK <= x_wide) &&
             (x_wide + EDGE_SHRINK <= 10'(rect_ff[i].right)) &&
             (10'(rect_ff[i].top) + EDGE_SHRINK <= y_hit) &&
             (y_hit + EDGE_SHRINK <= 10'(rect_ff[i].bottom))) begin
            hit_valid = 1'b1;
            hit_index = 2'(i);
         end
      end
   end

   // ------------------------------------------------------------------
   // Key phase machine: waiting for a press, confirming a candidate, and
   // pressed. A trigger on an enabled button makes it the candidate. The
   // press is confirmed once enough pressing samples land on it (one with
   // RF active). Leaving the button before that drops back to waiting
   // silently; after confirmation, lifting reports a release and sliding
   // off reports a cancel.
   // ------------------------------------------------------------------
   phase_type       phase_ff;
   phase_type       phase_in;
   logic [1:0]      cand_index_ff;
   logic [1:0]      cand_index_in;
   logic [3:0]      press_count_ff;
   logic [3:0]      press_count_in;
   logic            was_touching_ff;
   touch_phase_type touch_phase;
   key_event_type   key_event;
   logic [1:0]      key_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PHASE_WAIT;
         cand_index_ff   <= 2'd0;
         press_count_ff  <= 4'd0;
         was_touching_ff <= 1'b0;
      end else if (advance) begin
         phase_ff        <= phase_in;
         cand_index_ff   <= cand_index_in;
         press_count_ff  <= press_count_in;
         was_touching_ff <= touching_ff;
      end
   end

   always_comb begin
      logic [3:0] need;
      logic [3:0] count_next;
      logic       on_cand;

      need       = rf_ff ? CONFIRM_COUNT_RF : confirm_count_ff;
      count_next = press_count_ff + 4'd1;
      on_cand    = hit_valid && (hit_index == cand_index_ff);

      if (!touching_ff) begin
         touch_phase = TP_RELEASE;
      end else if (was_touching_ff) begin
         touch_phase = TP_PRESSING;
      end else begin
         touch_phase = TP_TRIGGER;
      end

      phase_in       = phase_ff;
      cand_index_in  = cand_index_ff;
      press_count_in = press_count_ff;
      key_event      = EV_NONE;
      key_index      = 2'd0;

      unique case (phase_ff)
         PHASE_CONFIRM: begin
            if (touch_phase == TP_PRESSING) begin
               if (on_cand) begin
                  if (count_next >= need) begin
                     key_event      = EV_PRESS;
                     key_index      = cand_index_ff;
                     press_count_in = 4'd0;
                     phase_in       = PHASE_PRESSED;
                  end else begin
                     press_count_in = count_next;
                  end
               end else begin
                  press_count_in = 4'd0;
                  phase_in       = PHASE_WAIT;
               end
            end else if (touch_phase == TP_TRIGGER) begin
               // A new touch on any enabled button restarts the count on it.
               if (hit_valid) begin
                  cand_index_in  = hit_index;
                  press_count_in = 4'd0;
               end
            end else begin
               press_count_in = 4'd0;
               phase_in       = PHASE_WAIT;
            end
         end
         PHASE_PRESSED: begin
            if (touch_phase == TP_RELEASE) begin
               key_event      = EV_RELEASE;
               key_index      = cand_index_ff;
               press_count_in = 4'd0;
               phase_in       = PHASE_WAIT;
            end else if (!on_cand) begin
               key_event      = EV_CANCEL;
               key_index      = cand_index_ff;
               press_count_in = 4'd0;
               phase_in       = PHASE_WAIT;
            end
         end
         default: begin
            phase_in = PHASE_WAIT;
            if ((touch_phase == TP_TRIGGER) && hit_valid) begin
               cand_index_in  = hit_index;
               press_count_in = 4'd0;
               phase_in       = PHASE_CONFIRM;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Result register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_event_ff <= key_event;
         rsp_index_ff <= key_index;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.key_event = rsp_event_ff;
   assign rsp_if.key_index = rsp_index_ff;

endmodule

`default_nettype wire
